// ===== rtl/core/hwp_pkg.sv =====
// shared constants, types and register codes of the heightmap wireframe projector
`default_nettype none
package hwp_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int WID_W      = COL_W + 1;
  localparam int ROW_W      = 10;
  localparam int GRID_W     = 11;
  localparam int COORD_W    = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int FRAC_BITS  = 23;
  localparam int HD_SHIFT   = 15;
  localparam int HD_W       = 32;
  localparam int IDX_MAX_W  = (COL_W > ROW_W) ? COL_W : ROW_W;
  localparam int PROD_W     = IDX_MAX_W + 17;
  localparam int ROT_W      = PROD_W + 1;
  localparam int ZPROD_W    = ROT_W + 17;
  localparam int Q_W        = ((ZPROD_W > HD_W + HD_SHIFT) ? ZPROD_W : HD_W + HD_SHIFT) + 3;
  localparam int FLOOR_W    = Q_W - FRAC_BITS;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_GRID_WIDTH = 3'd0,
    REG_ROT_COS    = 3'd1,
    REG_ROT_SIN    = 3'd2,
    REG_ZOOM       = 3'd3,
    REG_POS_X      = 3'd4,
    REG_POS_Y      = 3'd5,
    REG_DEPTH_GAIN = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic        [GRID_W-1:0]  grid_width;
    logic signed [COORD_W-1:0] rot_cos;
    logic signed [COORD_W-1:0] rot_sin;
    logic        [COORD_W-1:0] zoom;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
    logic signed [COORD_W-1:0] depth_gain;
  } cfg_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } point_t;

endpackage
`default_nettype wire

// ===== rtl/core/hwp_if.sv =====
// valid/ready channels for the sample input and the segment output
`default_nettype none
interface hwp_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] height;
  logic               frame_start;

  modport source (output valid, output height, output frame_start, input ready);
  modport sink (input valid, input height, input frame_start, output ready);
endinterface

interface hwp_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] start_x;
  logic signed [15:0] start_y;
  logic signed [15:0] end_x;
  logic signed [15:0] end_y;
  logic               last;

  modport source (output valid, output start_x, output start_y, output end_x, output end_y,
                  output last, input ready);
  modport sink (input valid, input start_x, input start_y, input end_x, input end_y,
                input last, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/heightmap_wireframe_projector_unit.sv =====
// heightmap wireframe projector: grid walk, line buffer and segment output
//
// in_ch carries one height sample per item in raster order; frame_start on an
// item restarts the walk at column 0, row 0. out_ch carries segments: the
// left one (when the column is not 0) and then the one from above (when the
// row is not 0), with last set on the final segment of a sample.
// cfg_we/cfg_index/cfg_data write the seven registers; write only while idle.
// One sample is in flight at a time: the item is accepted, runs through the
// four-stage multiply pipeline, and its segments are pushed into the output
// register. After the four pipeline stages the point is loaded, then each
// segment is pushed in turn while the output register has room (a sample
// with no segment still passes once through the push state).
// The line buffer is a 1024 x 32 synchronous memory read at accept and
// written when the sample retires; it needs no clearing.
// Reset (synchronous) loads register defaults, clears the grid position and
// the left point, and empties the output register.
// When the receiver stalls, the segment waits in the output register and the
// block holds; the next sample is accepted as soon as the last segment of
// the current one has been loaded, even if it has not yet been taken.
`default_nettype none
module heightmap_wireframe_projector_unit import hwp_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  hwp_in_if.sink                in_ch,
  hwp_out_if.source             out_ch
);

  typedef enum logic [1:0] {ST_IDLE, ST_CALC, ST_EMIT} state_t;

  state_t state;
  cfg_t   cfg;

  logic [COL_W-1:0] col_index;
  logic [ROW_W-1:0] row_index;
  point_t           left_point;
  point_t           cur_pt;
  logic [COL_W-1:0] item_col;
  logic             need_left;
  logic             need_up;

  point_t row_mem [MAX_WIDTH];
  point_t mem_q;

  logic             in_accept;
  logic [COL_W-1:0] col_eff;
  logic [ROW_W-1:0] row_eff;
  logic [WID_W-1:0] width_eff;
  logic             slot_free;
  logic             emit_done;
  logic             proj_done;
  point_t           proj_pt;

  logic               out_valid;
  logic signed [15:0] out_sx, out_sy, out_ex, out_ey;
  logic               out_last;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.grid_width <= GRID_W'(1);
      cfg.rot_cos    <= 16'sd16384;
      cfg.rot_sin    <= '0;
      cfg.zoom       <= 16'd256;
      cfg.pos_x      <= '0;
      cfg.pos_y      <= '0;
      cfg.depth_gain <= 16'sd256;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_GRID_WIDTH: cfg.grid_width <= cfg_data[GRID_W-1:0];
        REG_ROT_COS:    cfg.rot_cos    <= cfg_data;
        REG_ROT_SIN:    cfg.rot_sin    <= cfg_data;
        REG_ZOOM:       cfg.zoom       <= cfg_data;
        REG_POS_X:      cfg.pos_x      <= cfg_data;
        REG_POS_Y:      cfg.pos_y      <= cfg_data;
        REG_DEPTH_GAIN: cfg.depth_gain <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    in_accept = in_ch.valid && in_ch.ready;
    col_eff   = in_ch.frame_start ? '0 : col_index;
    row_eff   = in_ch.frame_start ? '0 : row_index;
    if (cfg.grid_width == '0)
      width_eff = WID_W'(1);
    else if (32'(cfg.grid_width) > MAX_WIDTH)
      width_eff = WID_W'(MAX_WIDTH);
    else
      width_eff = WID_W'(cfg.grid_width);
    slot_free = !out_valid || out_ch.ready;
    emit_done = (state == ST_EMIT) && slot_free && !(need_left && need_up);
  end

  assign in_ch.ready = (state == ST_IDLE);

  hwp_project u_project (
    .clk    (clk),
    .rst    (rst),
    .start  (in_accept),
    .col    (col_eff),
    .row    (row_eff),
    .height (in_ch.height),
    .cfg    (cfg),
    .done   (proj_done),
    .pt     (proj_pt)
  );

  // line buffer: read at accept, written when the sample retires
  always_ff @(posedge clk) begin
    if (in_accept) mem_q <= row_mem[col_eff];
    if (emit_done) row_mem[item_col] <= cur_pt;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      col_index  <= '0;
      row_index  <= '0;
      left_point <= '0;
      need_left  <= 1'b0;
      need_up    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      // a taken segment is dropped unless the next one is loaded this cycle
      if (out_valid && out_ch.ready && !(state == ST_EMIT && (need_left || need_up)))
        out_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            item_col  <= col_eff;
            need_left <= (col_eff != '0);
            need_up   <= (row_eff != '0);
            if (WID_W'(col_eff) + WID_W'(1) >= width_eff) begin
              col_index <= '0;
              row_index <= row_eff + ROW_W'(1);
            end else begin
              col_index <= col_eff + COL_W'(1);
              row_index <= row_eff;
            end
            state <= ST_CALC;
          end
        end
        ST_CALC: begin
          if (proj_done) begin
            cur_pt <= proj_pt;
            state  <= ST_EMIT;
          end
        end
        ST_EMIT: begin
          if (slot_free) begin
            if (need_left) begin
              out_valid <= 1'b1;
              out_sx    <= left_point.x;
              out_sy    <= left_point.y;
              out_ex    <= cur_pt.x;
              out_ey    <= cur_pt.y;
              out_last  <= !need_up;
              need_left <= 1'b0;
            end else if (need_up) begin
              out_valid <= 1'b1;
              out_sx    <= mem_q.x;
              out_sy    <= mem_q.y;
              out_ex    <= cur_pt.x;
              out_ey    <= cur_pt.y;
              out_last  <= 1'b1;
              need_up   <= 1'b0;
            end
            if (emit_done) begin
              left_point <= cur_pt;
              state      <= ST_IDLE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  assign out_ch.valid   = out_valid;
  assign out_ch.start_x = out_sx;
  assign out_ch.start_y = out_sy;
  assign out_ch.end_x   = out_ex;
  assign out_ch.end_y   = out_ey;
  assign out_ch.last    = out_last;

  // a taken segment that is not last is followed at once by the upper one
  a_second_follows: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.ready && !out_ch.last) |=> out_ch.valid)
    else $error("second segment of a sample not loaded");

  // a waiting non-last segment means the upper segment is still pending
  a_up_pending: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && !out_ch.last) |-> need_up)
    else $error("non-last segment without a pending upper segment");

  // the pipeline only finishes for the sample being worked on
  a_proj_in_calc: assert property (@(posedge clk) disable iff (rst)
    proj_done |-> (state == ST_CALC))
    else $error("projection finished outside of calc state");

endmodule
`default_nettype wire

// ===== rtl/core/hwp_project.sv =====
// four-stage projection pipeline: rotate, zoom, offset, floor and saturate
`default_nettype none
module hwp_project import hwp_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [COL_W-1:0]          col,
  input  logic [ROW_W-1:0]          row,
  input  logic signed [COORD_W-1:0] height,
  input  cfg_t                      cfg,
  output logic                      done,
  output point_t                    pt
);

  localparam logic signed [FLOOR_W-1:0] SAT_HI = FLOOR_W'(32767);
  localparam logic signed [FLOOR_W-1:0] SAT_LO = FLOOR_W'(-32768);

  logic [2:0] stage_v;

  logic signed [PROD_W-1:0]  m_cc, m_rs, m_cs, m_rc;
  logic signed [HD_W-1:0]    m_hd, hd2, hd3;
  logic signed [ROT_W-1:0]   rx, ry;
  logic signed [ZPROD_W-1:0] zx, zy;
  logic signed [Q_W-1:0]     xq, yq;
  logic signed [FLOOR_W-1:0] xf, yf;

  function automatic logic signed [COORD_W-1:0] sat(input logic signed [FLOOR_W-1:0] v);
    logic signed [FLOOR_W-1:0] c;
    c = v;
    if (v > SAT_HI) c = SAT_HI;
    if (v < SAT_LO) c = SAT_LO;
    return c[COORD_W-1:0];
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_v <= '0;
      done    <= 1'b0;
    end else begin
      stage_v <= {stage_v[1:0], start};
      done    <= stage_v[2];
    end
  end

  // stage 1: rotation products and height term
  always_ff @(posedge clk) begin
    m_cc <= $signed({1'b0, col}) * cfg.rot_cos;
    m_rs <= $signed({1'b0, row}) * cfg.rot_sin;
    m_cs <= $signed({1'b0, col}) * cfg.rot_sin;
    m_rc <= $signed({1'b0, row}) * cfg.rot_cos;
    m_hd <= height * cfg.depth_gain;
  end

  // stage 2: rotated coordinates
  always_ff @(posedge clk) begin
    rx  <= {m_cc[PROD_W-1], m_cc} - {m_rs[PROD_W-1], m_rs};
    ry  <= {m_cs[PROD_W-1], m_cs} + {m_rc[PROD_W-1], m_rc};
    hd2 <= m_hd;
  end

  // stage 3: zoom
  always_ff @(posedge clk) begin
    zx  <= rx * $signed({1'b0, cfg.zoom});
    zy  <= ry * $signed({1'b0, cfg.zoom});
    hd3 <= hd2;
  end

  // stage 4: sum in Q.23, floor by arithmetic shift, saturate
  always_comb begin
    xq = (Q_W'(zx) <<< 1) + (Q_W'(cfg.pos_x) <<< FRAC_BITS);
    yq = Q_W'(zy) + (Q_W'(cfg.pos_y) <<< FRAC_BITS) - (Q_W'(hd3) <<< HD_SHIFT);
    xf = xq[Q_W-1:FRAC_BITS];
    yf = yq[Q_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    pt.x <= sat(xf);
    pt.y <= sat(yf);
  end

endmodule
`default_nettype wire

// ===== test/tb_heightmap_wireframe_projector_unit.sv =====
// testbench of the heightmap wireframe projector: directed table, then random frames and settings
`timescale 1ns / 100ps
module tb_heightmap_wireframe_projector_unit import hwp_pkg::*; ();

  typedef struct packed {
    logic signed [COORD_W-1:0] sx;
    logic signed [COORD_W-1:0] sy;
    logic signed [COORD_W-1:0] ex;
    logic signed [COORD_W-1:0] ey;
    logic                      last;
  } seg_t;

  typedef enum logic {STEP_ITEM, STEP_REG} step_kind_t;

  typedef struct {
    step_kind_t            kind;
    cfg_reg_t              addr;
    logic [CFG_DATA_W-1:0] data;
    logic signed [15:0]    height;
    logic                  fs;
    bit                    typed;
    bit                    typed_seg;
    seg_t                  seg;
  } dir_step_t;

  localparam int WRAP_PHASE    = 2;
  localparam int WIDE_PHASE    = 5;
  localparam int RANDOM_ITEMS  = 1750;
  localparam int SETTLE_CYCLES = 12;
  localparam int MAX_REPORTS   = 10;

  logic                  clk;
  logic                  rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  hwp_in_if  smp_ch ();
  hwp_out_if seg_ch ();

  heightmap_wireframe_projector_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (smp_ch),
    .out_ch    (seg_ch)
  );

  // register copies and grid walk state of the predictor
  logic [GRID_W-1:0]   cfg_width;
  logic signed [15:0]  cfg_cos;
  logic signed [15:0]  cfg_sin;
  logic [15:0]         cfg_zoom;
  logic signed [15:0]  cfg_px;
  logic signed [15:0]  cfg_py;
  logic signed [15:0]  cfg_gain;
  logic [COL_W-1:0]    col_pos;
  logic [ROW_W-1:0]    row_pos;
  point_t              left_pt;
  point_t              line_buf [MAX_WIDTH];
  bit                  line_buf_set [MAX_WIDTH];

  seg_t      due_segments [$];
  dir_step_t dir_tab [$];

  int mismatches;
  int samples_sent;
  int segs_seen;
  int settings_used;
  int row_wraps;
  bit steady;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("FAILED: results differ");
    $finish;
  end

  function automatic int unsigned pick_gap();
    return steady ? 0 : $urandom_range(0, 13);
  endfunction

  function automatic logic signed [15:0] clamp16(longint v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic point_t project_point(int col, int row, logic signed [15:0] h);
    longint rx, ry, xq, yq;
    point_t p;
    rx = longint'(col) * longint'(cfg_cos) - longint'(row) * longint'(cfg_sin);
    ry = longint'(col) * longint'(cfg_sin) + longint'(row) * longint'(cfg_cos);
    // everything lands in q.23: zoom doubles on x, stays as is (half) on y
    xq = rx * longint'(cfg_zoom) * 2 + (longint'(cfg_px) <<< FRAC_BITS);
    yq = ry * longint'(cfg_zoom) + (longint'(cfg_py) <<< FRAC_BITS)
         - longint'(h) * longint'(cfg_gain) * (longint'(1) <<< HD_SHIFT);
    p.x = clamp16(xq >>> FRAC_BITS);
    p.y = clamp16(yq >>> FRAC_BITS);
    return p;
  endfunction

  task automatic walk_grid(logic signed [15:0] h, logic fs, bit typed, bit typed_seg,
                           seg_t typed_val);
    point_t p;
    seg_t   made [2];
    int     n;
    int     width;
    n = 0;
    width = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
    if (fs) begin
      col_pos = '0;
      row_pos = '0;
    end
    p = project_point(int'(col_pos), int'(row_pos), h);
    if (col_pos != 0) begin
      made[n] = '{left_pt.x, left_pt.y, p.x, p.y, 1'b0};
      n++;
    end
    if (row_pos != 0) begin
      made[n] = '{line_buf[col_pos].x, line_buf[col_pos].y, p.x, p.y, 1'b0};
      n++;
    end
    if (n > 0) made[n-1].last = 1'b1;
    if (typed) begin
      if (typed_seg) due_segments.push_back(typed_val);
    end else begin
      for (int i = 0; i < n; i++) due_segments.push_back(made[i]);
    end
    line_buf[col_pos] = p;
    line_buf_set[col_pos] = 1'b1;
    left_pt = p;
    if (int'(col_pos) + 1 >= width) begin
      col_pos = '0;
      if (&row_pos) row_wraps++;
      row_pos = row_pos + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
    end
  endtask

  task automatic write_reg(cfg_reg_t addr, logic [CFG_DATA_W-1:0] data);
    case (addr)
      REG_GRID_WIDTH: cfg_width = data[GRID_W-1:0];
      REG_ROT_COS:    cfg_cos   = data;
      REG_ROT_SIN:    cfg_sin   = data;
      REG_ZOOM:       cfg_zoom  = data;
      REG_POS_X:      cfg_px    = data;
      REG_POS_Y:      cfg_py    = data;
      REG_DEPTH_GAIN: cfg_gain  = data;
      default: ;
    endcase
    cfg_we    <= 1'b1;
    cfg_index <= addr;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic settle();
    smp_ch.valid <= 1'b0;
    while (due_segments.size() != 0) @(posedge clk);
    // a sample with no segment may still be in the pipeline
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic send_sample(logic signed [15:0] h, logic fs, bit typed = 0,
                             bit typed_seg = 0, seg_t typed_val = '0);
    int unsigned gap;
    gap = pick_gap();
    // never read a line buffer entry that was not written since reset
    if (!fs && row_pos != 0 && !line_buf_set[col_pos]) fs = 1'b1;
    if (gap != 0) begin
      smp_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    smp_ch.valid       <= 1'b1;
    smp_ch.height      <= h;
    smp_ch.frame_start <= fs;
    do @(posedge clk); while (!smp_ch.ready);
    walk_grid(h, fs, typed, typed_seg, typed_val);
    samples_sent++;
  endtask

  task automatic add_reg(cfg_reg_t addr, int v);
    dir_step_t st;
    st.kind = STEP_REG;
    st.addr = addr;
    st.data = v[CFG_DATA_W-1:0];
    st.height = '0;
    st.fs = 1'b0;
    st.typed = 1'b0;
    st.typed_seg = 1'b0;
    st.seg = '0;
    dir_tab.push_back(st);
  endtask

  task automatic add_item(logic signed [15:0] h, logic fs, bit typed = 0, bit typed_seg = 0,
                          seg_t seg = '0);
    dir_step_t st;
    st.kind = STEP_ITEM;
    st.addr = REG_GRID_WIDTH;
    st.data = '0;
    st.height = h;
    st.fs = fs;
    st.typed = typed;
    st.typed_seg = typed_seg;
    st.seg = seg;
    dir_tab.push_back(st);
  endtask

  function automatic logic [15:0] pick_trig();
    int v;
    case ($urandom_range(0, 7))
      0: v = -16384;
      1: v = 0;
      2: v = 16384;
      default: v = int'($urandom_range(0, 32768)) - 16384;
    endcase
    return v[15:0];
  endfunction

  function automatic logic [15:0] pick_span(int lim);
    int v;
    case ($urandom_range(0, 9))
      0: v = 32767;
      1: v = -32768;
      default: v = int'($urandom_range(0, 2 * lim)) - lim;
    endcase
    return v[15:0];
  endfunction

  function automatic logic signed [15:0] pick_height();
    int v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 1) ? 32767 : -32768;
      1, 2: v = $urandom;
      default: v = int'($urandom_range(0, 200)) - 100;
    endcase
    return v[15:0];
  endfunction

  task automatic pick_settings(int phase);
    int w;
    if (phase == WRAP_PHASE) w = 0;
    else if (phase == WIDE_PHASE) w = 2047;
    else begin
      case ($urandom_range(0, 9))
        0: w = 1;
        1, 2: w = $urandom_range(13, 80);
        default: w = $urandom_range(2, 12);
      endcase
    end
    write_reg(REG_GRID_WIDTH, CFG_DATA_W'(w));
    write_reg(REG_ROT_COS, pick_trig());
    write_reg(REG_ROT_SIN, pick_trig());
    if ($urandom_range(0, 4) == 0) write_reg(REG_ZOOM, $urandom_range(0, 1) ? 16'hffff : 16'h0);
    else write_reg(REG_ZOOM, CFG_DATA_W'($urandom_range(0, 1024)));
    write_reg(REG_POS_X, pick_span(200));
    write_reg(REG_POS_Y, pick_span(200));
    write_reg(REG_DEPTH_GAIN, pick_span(512));
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  task automatic report_bad(string why, seg_t want, seg_t got);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s: expected (%0d,%0d)->(%0d,%0d) last %0b, got (%0d,%0d)->(%0d,%0d) last %0b",
               $realtime, why, want.sx, want.sy, want.ex, want.ey, want.last,
               got.sx, got.sy, got.ex, got.ey, got.last);
  endtask

  // segment taker with random stalls
  initial begin : seg_taker
    int unsigned gap;
    seg_ch.ready <= 1'b0;
    @(posedge clk);
    forever begin
      gap = pick_gap();
      if (gap != 0) begin
        seg_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      seg_ch.ready <= 1'b1;
      do @(posedge clk); while (!(seg_ch.valid && seg_ch.ready));
    end
  end

  always @(posedge clk) begin : seg_check
    seg_t got, want;
    if (!rst && seg_ch.valid && seg_ch.ready) begin
      got = '{seg_ch.start_x, seg_ch.start_y, seg_ch.end_x, seg_ch.end_y, seg_ch.last};
      segs_seen++;
      if (due_segments.size() == 0) begin
        report_bad("segment with none expected", '0, got);
      end else begin
        want = due_segments.pop_front();
        if (got.sx !== want.sx || got.sy !== want.sy || got.ex !== want.ex ||
            got.ey !== want.ey || got.last !== want.last)
          report_bad("segment mismatch", want, got);
      end
    end
  end

  initial begin : main_seq
    int   phase;
    int   quota;
    int   n;
    bit   in_cfg;
    logic fs;
    rst                <= 1'b1;
    cfg_we             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    smp_ch.valid       <= 1'b0;
    smp_ch.height      <= '0;
    smp_ch.frame_start <= 1'b0;
    cfg_width = 11'd1;
    cfg_cos   = 16'sd16384;
    cfg_sin   = '0;
    cfg_zoom  = 16'd256;
    cfg_px    = '0;
    cfg_py    = '0;
    cfg_gain  = 16'sd256;
    col_pos   = '0;
    row_pos   = '0;
    left_pt   = '0;
    foreach (line_buf_set[i]) line_buf_set[i] = 1'b0;
    mismatches = 0;
    samples_sent = 0;
    segs_seen = 0;
    settings_used = 1;
    row_wraps = 0;
    steady = 1'b0;

    // register defaults: width 1, unit zoom and gain, so each sample stacks under the last
    add_item(16'sd0, 1'b1, 1, 0);
    add_item(16'sd100, 1'b0, 1, 1, '{16'sd0, 16'sd0, 16'sd0, -16'sd100, 1'b1});
    add_item(-16'sd32768, 1'b0, 1, 1, '{16'sd0, -16'sd100, 16'sd0, 16'sd32767, 1'b1});
    add_item(16'sd32767, 1'b0, 1, 1, '{16'sd0, 16'sd32767, 16'sd0, -16'sd32766, 1'b1});
    // width 0 acts as 1
    add_reg(REG_GRID_WIDTH, 0);
    add_item(16'sd0, 1'b0, 1, 1, '{16'sd0, -16'sd32766, 16'sd0, 16'sd2, 1'b1});
    // one extreme corner of every register
    add_reg(REG_GRID_WIDTH, 3);
    add_reg(REG_ROT_COS, -16384);
    add_reg(REG_ROT_SIN, 16384);
    add_reg(REG_ZOOM, 65535);
    add_reg(REG_POS_X, 32767);
    add_reg(REG_POS_Y, -32768);
    add_reg(REG_DEPTH_GAIN, -32768);
    add_item(-16'sd32768, 1'b1);
    add_item(16'sd32767, 1'b0);
    add_item(16'sd0, 1'b0);
    add_item(-16'sd1, 1'b0);
    add_item(16'sd1, 1'b0);
    add_item(16'sd12345, 1'b0);
    // the other corner, with width above the maximum
    add_reg(REG_GRID_WIDTH, 2047);
    add_reg(REG_ROT_COS, 0);
    add_reg(REG_ROT_SIN, -16384);
    add_reg(REG_ZOOM, 0);
    add_reg(REG_POS_X, -32768);
    add_reg(REG_POS_Y, 32767);
    add_reg(REG_DEPTH_GAIN, 32767);
    add_item(-16'sd32768, 1'b1);
    add_item(16'sd32767, 1'b0);
    add_item(-16'sd1, 1'b0);
    add_item(16'sd0, 1'b0);
    // width cut mid-row: the column is already past it
    add_reg(REG_GRID_WIDTH, 2);
    add_item(16'sd100, 1'b0);
    add_item(-16'sd100, 1'b0);
    add_item(16'sd7, 1'b0);
    add_item(16'sd55, 1'b1);
    add_item(-16'sd55, 1'b0);

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    in_cfg = 1'b0;
    foreach (dir_tab[k]) begin
      if (dir_tab[k].kind == STEP_REG) begin
        if (!in_cfg) begin
          settle();
          in_cfg = 1'b1;
          settings_used++;
        end
        write_reg(dir_tab[k].addr, dir_tab[k].data);
      end else begin
        if (in_cfg) begin
          cfg_we <= 1'b0;
          in_cfg = 1'b0;
        end
        send_sample(dir_tab[k].height, dir_tab[k].fs, dir_tab[k].typed,
                    dir_tab[k].typed_seg, dir_tab[k].seg);
      end
    end

    phase = 0;
    quota = 0;
    while (quota < RANDOM_ITEMS) begin
      settle();
      steady = ($urandom_range(0, 3) == 0);
      pick_settings(phase);
      if (phase == WRAP_PHASE) n = 1030;
      else if (phase == WIDE_PHASE) n = 240;
      else n = $urandom_range(30, 110);
      for (int k = 0; k < n; k++) begin
        if (k == 0)
          fs = (phase == WRAP_PHASE || phase == WIDE_PHASE) ? 1'b1 : 1'($urandom_range(0, 1));
        else fs = (phase != WRAP_PHASE) && ($urandom_range(0, 39) == 0);
        send_sample(pick_height(), fs);
      end
      quota += n;
      phase++;
    end
    steady = 1'b0;
    settle();

    $display("run covered %0d samples under %0d register settings, %0d segments compared",
             samples_sent, settings_used, segs_seen);
    $display("row index wrapped %0d times, %0d mismatches", row_wraps, mismatches);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

// ===== heightmap_wireframe_projector_unit.f =====
rtl/core/hwp_pkg.sv
rtl/core/hwp_if.sv
rtl/core/hwp_project.sv
rtl/core/heightmap_wireframe_projector_unit.sv
test/tb_heightmap_wireframe_projector_unit.sv
